>>> hw/rtl/elf_relocation_patch_engine_core_assert.svh
// assertion macros for the relocation patch engine checker
`ifndef ELF_RELOCATION_PATCH_ENGINE_CORE_ASSERT_SVH
`define ELF_RELOCATION_PATCH_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define ERPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relocation engine check failed");

// next-cycle implication
`define ERPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relocation engine check failed");

`endif

>>> hw/rtl/erpe_pkg.sv
// shared types and constants of the relocation patch engine
`default_nettype none

package erpe_pkg;

    localparam int SYMBOL_DEPTH = 1024;
    localparam int SYM_AW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;
    localparam logic [31:0] SYM_LIMIT = 32'(SYMBOL_DEPTH);
    localparam int SYM_W = 64;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_RELOC = 1'b1;

    localparam logic [31:0] REL_NONE  = 32'd0;
    localparam logic [31:0] REL_64    = 32'd1;
    localparam logic [31:0] REL_PC32  = 32'd2;
    localparam logic [31:0] REL_PLT32 = 32'd4;
    localparam logic [31:0] REL_32    = 32'd10;
    localparam logic [31:0] REL_32S   = 32'd11;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NONE   = 3'd1;
    localparam logic [2:0] ST_BADSYM = 3'd2;
    localparam logic [2:0] ST_BADOFF = 3'd3;
    localparam logic [2:0] ST_OVF    = 3'd4;
    localparam logic [2:0] ST_UNSUP  = 3'd5;
    localparam logic [2:0] ST_SUPP   = 3'd6;

    localparam logic [3:0] BYTES_8 = 4'd8;
    localparam logic [3:0] BYTES_4 = 4'd4;

    localparam logic [1:0] CFG_TARGET_BASE  = 2'd0;
    localparam logic [1:0] CFG_SECTION_SIZE = 2'd1;
    localparam logic [1:0] CFG_SYMBOL_COUNT = 2'd2;

    typedef enum logic [2:0] {
        K_64,
        K_PC,
        K_U32,
        K_S32,
        K_UNSUP
    } kind_t;

    typedef struct packed {
        logic        write_enable;
        logic [63:0] write_address;
        logic [63:0] write_data;
        logic [3:0]  write_bytes;
        logic [2:0]  status;
    } res_t;

    typedef struct packed {
        logic [63:0] sum;
        logic [63:0] where;
        kind_t       kind;
        logic [2:0]  pre_status;
    } check_t;

endpackage

`default_nettype wire

>>> hw/rtl/erpe_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
`default_nettype none

module erpe_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [AW-1:0]    waddr_w;
    logic [AW-1:0]    raddr_w;

    assign waddr_w = waddr;
    assign raddr_w = raddr;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr_w] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr_w];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/erpe_reloc.sv
// relocation checks, sums and range tests over two stages
`default_nettype none

module erpe_reloc (
    input  wire logic                clk,
    input  wire logic                check_en,
    input  wire logic [31:0]         rel_type,
    input  wire logic [31:0]         sym_index,
    input  wire logic [63:0]         patch_offset,
    input  wire logic signed [63:0]  addend,
    input  wire logic [63:0]         sym_value,
    input  wire logic [63:0]         target_base,
    input  wire logic [31:0]         section_size,
    input  wire logic [10:0]         symbol_count,
    output erpe_pkg::res_t           res
);

    import erpe_pkg::*;

    check_t      chk_reg;
    check_t      chk_next;
    logic        bad_sym;
    logic        bad_off;
    logic        width8;
    logic [31:0] remain;
    logic [31:0] need;
    kind_t       kind;
    logic [63:0] diff;
    logic [63:0] v;
    logic        fit_s;
    logic        fit_u;
    logic        ovf;

    // first stage: checks and the two base sums
    always_comb
    begin
        width8  = (rel_type == REL_64);
        need    = width8 ? 32'd8 : 32'd4;
        bad_sym = (sym_index >= {21'b0, symbol_count}) || (sym_index >= SYM_LIMIT);
        remain  = section_size - patch_offset[31:0];
        bad_off = (patch_offset > {32'b0, section_size}) || (remain < need);

        unique case (rel_type)
            REL_64:    kind = K_64;
            REL_PC32:  kind = K_PC;
            REL_PLT32: kind = K_PC;
            REL_32:    kind = K_U32;
            REL_32S:   kind = K_S32;
            default:   kind = K_UNSUP;
        endcase

        chk_next.sum   = sym_value + $unsigned(addend);
        chk_next.where = target_base + patch_offset;
        chk_next.kind  = kind;
        priority if (rel_type == REL_NONE)
            chk_next.pre_status = ST_NONE;
        else if (bad_sym)
            chk_next.pre_status = ST_BADSYM;
        else if (bad_off)
            chk_next.pre_status = ST_BADOFF;
        else if (kind == K_UNSUP)
            chk_next.pre_status = ST_UNSUP;
        else
            chk_next.pre_status = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (check_en)
        begin
            chk_reg <= chk_next;
        end
    end

    // second stage: pc-relative subtract and 32-bit range checks
    always_comb
    begin
        diff  = chk_reg.sum - chk_reg.where;
        v     = (chk_reg.kind == K_PC) ? diff : chk_reg.sum;
        fit_s = (v[63:31] == '0) || (v[63:31] == '1);
        fit_u = (v[63:32] == '0);

        unique case (chk_reg.kind)
            K_64:    ovf = 1'b0;
            K_PC:    ovf = !fit_s;
            K_U32:   ovf = !fit_u;
            K_S32:   ovf = !fit_s;
            default: ovf = 1'b0;
        endcase

        res = '0;
        if (chk_reg.pre_status != ST_OK)
        begin
            res.status = chk_reg.pre_status;
        end
        else if (ovf)
        begin
            res.status = ST_OVF;
        end
        else
        begin
            res.status        = ST_OK;
            res.write_enable  = 1'b1;
            res.write_address = chk_reg.where;
            if (chk_reg.kind == K_64)
            begin
                res.write_data  = v;
                res.write_bytes = BYTES_8;
            end
            else
            begin
                res.write_data  = {32'b0, v[31:0]};
                res.write_bytes = BYTES_4;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/elf_relocation_patch_engine_core.sv
// top level of the elf x86-64 relocation patch engine
//
//  channel   dir  handshake             payload
//  s_axis    in   tvalid / tready       tdata: item fields, tuser: opcode, tlast: last_entry
//  m_axis    out  tvalid / tready       tdata: write fields, tuser: enable+status, tlast
//  cfg       in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  one request at a time: a load goes straight to the finish state, a relocation passes
//  through symbol ram read, check/sum stage and subtract/range stage, plus any output stall
//  the result sits in an output register; the next request is taken as soon as
//  the result has moved there, so a waiting result does not hold the input
//  the symbol ram is not cleared by reset; reset clears config and the error latch
`default_nettype none

module elf_relocation_patch_engine_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // rel_type[31:0], sym_index[63:32], patch_offset[127:64], addend[191:128],
    // symbol_address[255:192]
    input  wire logic [255:0] s_axis_tdata,
    // opcode
    input  wire logic         s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // write_address[63:0], write_data[127:64], write_bytes[131:128], zero[135:132]
    output logic      [135:0] m_axis_tdata,
    // write_enable[0], status[3:1]
    output logic      [3:0]   m_axis_tuser,
    output logic              m_axis_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    import erpe_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_FIN   = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic        err_latched_reg;
    logic        err_latched_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    res_t        out_res_reg;
    logic        out_last_reg;

    logic [63:0] target_base_reg;
    logic [31:0] section_size_reg;
    logic [10:0] symbol_count_reg;

    logic               opcode_reg;
    logic [31:0]        rel_type_reg;
    logic [31:0]        sym_index_reg;
    logic [63:0]        patch_offset_reg;
    logic signed [63:0] addend_reg;
    logic               last_reg;

    logic        in_accept;
    logic        out_free;
    logic        check_en;
    logic        fin_fire;
    logic [31:0] in_sym;
    logic        ram_we;
    logic        ram_re;
    logic [63:0] sym_value;
    res_t        reloc_res;
    res_t        fin_res;
    logic        fin_last;
    logic        is_error;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign in_sym        = s_axis_tdata[63:32];
    assign ram_we        = in_accept && (s_axis_tuser == OP_LOAD) && (in_sym < SYM_LIMIT);
    assign ram_re        = in_accept && (s_axis_tuser == OP_RELOC);
    assign cfg_ready     = 1'b1;

    erpe_ram #(
        .DEPTH(SYMBOL_DEPTH),
        .WIDTH(SYM_W)
    ) u_symtab (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_sym[SYM_AW-1:0]),
        .wdata (s_axis_tdata[255:192]),
        .re    (ram_re),
        .raddr (in_sym[SYM_AW-1:0]),
        .rdata (sym_value)
    );

    erpe_reloc u_reloc (
        .clk          (clk),
        .check_en     (check_en),
        .rel_type     (rel_type_reg),
        .sym_index    (sym_index_reg),
        .patch_offset (patch_offset_reg),
        .addend       (addend_reg),
        .sym_value    (sym_value),
        .target_base  (target_base_reg),
        .section_size (section_size_reg),
        .symbol_count (symbol_count_reg),
        .res          (reloc_res)
    );

    always_comb
    begin
        state_next = state_reg;
        check_en   = 1'b0;
        fin_fire   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_axis_tuser == OP_RELOC) ? S_CHECK : S_FIN;
                end
            end
            S_CHECK:
            begin
                check_en   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    fin_fire   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result selection and error latch
    always_comb
    begin
        fin_res  = '0;
        fin_last = 1'b0;
        if (opcode_reg == OP_LOAD)
        begin
            fin_res.status = ST_OK;
        end
        else if (err_latched_reg)
        begin
            fin_res.status = ST_SUPP;
            fin_last       = last_reg;
        end
        else
        begin
            fin_res  = reloc_res;
            fin_last = last_reg;
        end

        is_error = (reloc_res.status == ST_BADSYM) || (reloc_res.status == ST_BADOFF) ||
                   (reloc_res.status == ST_OVF) || (reloc_res.status == ST_UNSUP);

        err_latched_next = err_latched_reg;
        if (fin_fire && (opcode_reg == OP_RELOC))
        begin
            if (last_reg)
                err_latched_next = 1'b0;
            else if (!err_latched_reg && is_error)
                err_latched_next = 1'b1;
        end

        m_valid_next = m_valid_reg;
        if (fin_fire)
            m_valid_next = 1'b1;
        else if (m_axis_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            err_latched_reg  <= 1'b0;
            m_valid_reg      <= 1'b0;
            target_base_reg  <= '0;
            section_size_reg <= '0;
            symbol_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            err_latched_reg <= err_latched_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_TARGET_BASE:  target_base_reg  <= cfg_data;
                    CFG_SECTION_SIZE: section_size_reg <= cfg_data[31:0];
                    CFG_SYMBOL_COUNT: symbol_count_reg <= cfg_data[10:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            opcode_reg       <= s_axis_tuser;
            rel_type_reg     <= s_axis_tdata[31:0];
            sym_index_reg    <= s_axis_tdata[63:32];
            patch_offset_reg <= s_axis_tdata[127:64];
            addend_reg       <= s_axis_tdata[191:128];
            last_reg         <= s_axis_tlast;
        end
        if (fin_fire)
        begin
            out_res_reg  <= fin_res;
            out_last_reg <= fin_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, out_res_reg.write_bytes, out_res_reg.write_data,
                            out_res_reg.write_address};
    assign m_axis_tuser  = {out_res_reg.status, out_res_reg.write_enable};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/erpe_checker.sv
// port-level checks of the relocation patch engine and their binding
`default_nettype none

`include "elf_relocation_patch_engine_core_assert.svh"

module erpe_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [135:0] m_axis_tdata,
    input  wire logic [3:0]   m_axis_tuser
);

    import erpe_pkg::*;

    `ERPE_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `ERPE_ASSERT_NEXT(a_one_request, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `ERPE_ASSERT_NOW(a_write_ok, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tuser[3:1] == ST_OK) && ((m_axis_tdata[131:128] == BYTES_8) || ((m_axis_tdata[131:128] == BYTES_4) && (m_axis_tdata[127:96] == 32'd0))))

    `ERPE_ASSERT_NOW(a_no_write_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 136'd0)

endmodule

bind elf_relocation_patch_engine_core erpe_checker u_checker (.*);

`default_nettype wire

>>> tb/reloc_tb_pkg.sv
// request and result types and the expected-patch tracker for the relocation engine testbench
package reloc_tb_pkg;

    import erpe_pkg::*;

    typedef struct {
        logic               opcode;
        logic        [31:0] rel_type;
        logic        [31:0] sym_index;
        logic        [63:0] patch_offset;
        logic signed [63:0] addend;
        logic        [63:0] symbol_address;
        logic               last_entry;
    } reloc_req_t;

    typedef struct {
        logic        write_enable;
        logic [63:0] write_address;
        logic [63:0] write_data;
        logic [3:0]  write_bytes;
        logic [2:0]  status;
        logic        batch_end;
    } patch_t;

    class reloc_patch_tracker;
        logic [63:0] sym_shadow [SYMBOL_DEPTH];
        bit          sym_loaded [SYMBOL_DEPTH];
        int unsigned loaded_list [$];
        logic [63:0] tgt_base = '0;
        logic [31:0] sec_size = '0;
        logic [10:0] sym_count = '0;
        bit          err_latch = 1'b0;
        patch_t      pending_patches [$];
        int          errors = 0;
        int          results_checked = 0;
        int          status_seen [8];

        function void set_register(logic [1:0] idx, logic [63:0] value);
            case (idx)
                CFG_TARGET_BASE:  tgt_base = value;
                CFG_SECTION_SIZE: sec_size = value[31:0];
                CFG_SYMBOL_COUNT: sym_count = value[10:0];
                default: ;
            endcase
        endfunction

        function void predict_patch(reloc_req_t rq);
            patch_t      p;
            logic [3:0]  width;
            logic [63:0] where_addr;
            logic [63:0] sum;
            logic [63:0] v;
            logic [2:0]  st;
            p = '{write_enable: 1'b0, write_address: '0, write_data: '0, write_bytes: '0,
                  status: ST_OK, batch_end: 1'b0};
            if (rq.opcode == OP_LOAD) begin
                if (rq.sym_index < SYM_LIMIT) begin
                    if (!sym_loaded[rq.sym_index[SYM_AW-1:0]])
                        loaded_list.push_back(rq.sym_index);
                    sym_shadow[rq.sym_index[SYM_AW-1:0]] = rq.symbol_address;
                    sym_loaded[rq.sym_index[SYM_AW-1:0]] = 1'b1;
                end
                pending_patches.push_back(p);
                return;
            end
            p.batch_end = rq.last_entry;
            if (err_latch) begin
                p.status = ST_SUPP;
            end
            else begin
                width = (rq.rel_type == REL_64) ? BYTES_8 : BYTES_4;
                where_addr = tgt_base + rq.patch_offset;
                v = '0;
                if (rq.rel_type == REL_NONE)
                    st = ST_NONE;
                else if (rq.sym_index >= {21'b0, sym_count} || rq.sym_index >= SYM_LIMIT)
                    st = ST_BADSYM;
                else if (rq.patch_offset > {32'b0, sec_size}
                         || ({32'b0, sec_size} - rq.patch_offset) < 64'(width))
                    st = ST_BADOFF;
                else begin
                    sum = sym_shadow[rq.sym_index[SYM_AW-1:0]] + rq.addend;
                    st = ST_OK;
                    case (rq.rel_type)
                        REL_64: v = sum;
                        REL_PC32, REL_PLT32:
                        begin
                            v = sum - where_addr;
                            if (((v + 64'h8000_0000) >> 32) != 64'd0)
                                st = ST_OVF;
                        end
                        REL_32:
                        begin
                            v = sum;
                            if (v[63:32] != 32'd0)
                                st = ST_OVF;
                        end
                        REL_32S:
                        begin
                            v = sum;
                            if (((v + 64'h8000_0000) >> 32) != 64'd0)
                                st = ST_OVF;
                        end
                        default: st = ST_UNSUP;
                    endcase
                end
                p.status = st;
                if (st == ST_OK) begin
                    p.write_enable = 1'b1;
                    p.write_address = where_addr;
                    p.write_data = (width == BYTES_8) ? v : {32'b0, v[31:0]};
                    p.write_bytes = width;
                end
                else if (st != ST_NONE) begin
                    err_latch = 1'b1;
                end
            end
            if (rq.last_entry)
                err_latch = 1'b0;
            pending_patches.push_back(p);
        endfunction

        task flag_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
            errors++;
            $display("mismatch on %s at result %0d: expected %0h, got %0h",
                     what, results_checked, want_v, got_v);
        endtask

        task compare_patch(patch_t got);
            patch_t want;
            if (pending_patches.size() == 0) begin
                flag_mismatch("result with no request pending", '0, '0);
                return;
            end
            want = pending_patches.pop_front();
            results_checked++;
            status_seen[want.status]++;
            if (got.write_enable !== want.write_enable)
                flag_mismatch("write_enable", want.write_enable, got.write_enable);
            if (got.write_address !== want.write_address)
                flag_mismatch("write_address", want.write_address, got.write_address);
            if (got.write_data !== want.write_data)
                flag_mismatch("write_data", want.write_data, got.write_data);
            if (got.write_bytes !== want.write_bytes)
                flag_mismatch("write_bytes", want.write_bytes, got.write_bytes);
            if (got.status !== want.status)
                flag_mismatch("status", want.status, got.status);
            if (got.batch_end !== want.batch_end)
                flag_mismatch("batch_end", want.batch_end, got.batch_end);
        endtask
    endclass

endpackage

>>> tb/tb_top.sv
// top-level testbench of the relocation patch engine: directed and random relocation batches
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import erpe_pkg::*;
    import reloc_tb_pkg::*;

    localparam int          STALL_LIMIT = 2000;
    localparam logic [63:0] DIR_BASE    = 64'h0000_7F00_1234_5000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    int src_idle_pct = 35;
    int dst_idle_pct = 49;
    int stall_cycles = 0;
    int requests_sent = 0;
    int settings_used = 0;

    reloc_patch_tracker tracker;

    elf_relocation_patch_engine_core dut (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // result side: random back-pressure and checking
    always @(posedge clk)
    begin : sink
        patch_t got;
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.write_address = m_axis_tdata[63:0];
                got.write_data    = m_axis_tdata[127:64];
                got.write_bytes   = m_axis_tdata[131:128];
                got.write_enable  = m_axis_tuser[0];
                got.status        = m_axis_tuser[3:1];
                got.batch_end     = m_axis_tlast;
                tracker.compare_patch(got);
            end
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_address();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(3))
            0: return tracker.tgt_base + 64'($urandom_range(0, tracker.sec_size));
            1: return {32'b0, w};
            2: return {{32{w[31]}}, w};
            default: return rand64();
        endcase
    endfunction

    function automatic logic [63:0] pick_addend();
        logic [63:0] edge_v;
        edge_v = $urandom_range(1) ? 64'h0000_0000_8000_0000 : 64'hFFFF_FFFF_8000_0000;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 64'($urandom_range(0, 65535)) - 64'd32768;
            5, 6: return edge_v + 64'($urandom_range(0, 8)) - 64'd4;
            7, 8: return rand64();
            default: return $urandom_range(1) ? 64'hFFFF_FFFF_FFFF_FFFC : 64'd0;
        endcase
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(11))
            0: return REL_NONE;
            1, 2: return REL_64;
            3, 4: return REL_PC32;
            5: return REL_PLT32;
            6, 7: return REL_32;
            8, 9: return REL_32S;
            10: return 32'($urandom_range(3, 15));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_loaded();
        if (tracker.loaded_list.size() == 0)
            return 32'hFFFF_FFFF;
        return tracker.loaded_list[$urandom_range(0, tracker.loaded_list.size() - 1)];
    endfunction

    // never reference a table entry that has not been loaded
    function automatic logic [31:0] pick_sym();
        logic [31:0] s;
        case ($urandom_range(9))
            0: s = 32'(tracker.sym_count) + $urandom_range(0, 3);
            1: s = $urandom;
            default:
            begin
                s = pick_loaded();
                for (int k = 0; k < 4; k++) begin
                    if (s < 32'(tracker.sym_count))
                        break;
                    s = pick_loaded();
                end
            end
        endcase
        if (s < SYM_LIMIT && !tracker.sym_loaded[s[SYM_AW-1:0]])
            s = pick_loaded();
        return s;
    endfunction

    function automatic logic [63:0] pick_offset();
        logic [63:0] sz;
        sz = {32'b0, tracker.sec_size};
        case ($urandom_range(19))
            0, 1: return sz - 64'($urandom_range(0, 9));
            2: return sz + 64'($urandom_range(1, 4));
            3, 4: return rand64();
            default:
                return 64'($urandom_range(0, (tracker.sec_size > 8) ? tracker.sec_size - 8 : 0));
        endcase
    endfunction

    function automatic logic [31:0] pick_load_index();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(0, SYMBOL_DEPTH - 1);
            default:
                return $urandom_range(0, (tracker.sym_count > 0) ? tracker.sym_count - 1 : 0);
        endcase
    endfunction

    function automatic reloc_req_t make_reloc(input logic last);
        reloc_req_t rq;
        rq.opcode         = OP_RELOC;
        rq.rel_type       = pick_type();
        rq.sym_index      = pick_sym();
        rq.patch_offset   = pick_offset();
        rq.addend         = pick_addend();
        rq.symbol_address = rand64();
        rq.last_entry     = last;
        return rq;
    endfunction

    function automatic reloc_req_t make_load(input logic [31:0] idx);
        reloc_req_t rq;
        rq.opcode         = OP_LOAD;
        rq.rel_type       = $urandom;
        rq.sym_index      = idx;
        rq.patch_offset   = rand64();
        rq.addend         = rand64();
        rq.symbol_address = pick_address();
        rq.last_entry     = $urandom_range(1);
        return rq;
    endfunction

    task automatic send_request(input reloc_req_t rq);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.symbol_address, rq.addend, rq.patch_offset, rq.sym_index,
                          rq.rel_type};
        s_axis_tuser  <= rq.opcode;
        s_axis_tlast  <= rq.last_entry;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.predict_patch(rq);
        requests_sent++;
    endtask

    task automatic send_fields(input logic op, input logic [31:0] ty, input logic [31:0] sym,
                               input logic [63:0] off, input logic [63:0] add,
                               input logic [63:0] sa, input logic last);
        reloc_req_t rq;
        rq = '{opcode: op, rel_type: ty, sym_index: sym, patch_offset: off, addend: add,
               symbol_address: sa, last_entry: last};
        send_request(rq);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_patches.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_registers(input logic [63:0] base, input logic [31:0] size,
                                 input logic [10:0] count);
        logic [63:0] vals [3];
        logic [1:0]  regs [3];
        vals = '{base, {32'b0, size}, {53'b0, count}};
        regs = '{CFG_TARGET_BASE, CFG_SECTION_SIZE, CFG_SYMBOL_COUNT};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.set_register(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input int n_requests, input int idle_mode);
        int goal;
        int len;
        case (idle_mode)
            0:
            begin
                src_idle_pct = 35;
                dst_idle_pct = 49;
            end
            1:
            begin
                src_idle_pct = 49;
                dst_idle_pct = 35;
            end
            default:
            begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end
        endcase
        goal = requests_sent + n_requests;
        for (int i = 0; i < 6; i++)
            send_request(make_load($urandom_range(0,
                (tracker.sym_count > 0) ? tracker.sym_count - 1 : 0)));
        while (requests_sent < goal) begin
            case ($urandom_range(19))
                0, 1: send_request(make_load(pick_load_index()));
                2: send_request(make_reloc($urandom_range(1)));
                // batch cut off without its closing entry
                3, 4:
                begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_request(make_reloc(1'b0));
                end
                default:
                begin
                    len = $urandom_range(1, 6);
                    for (int j = 1; j <= len; j++) begin
                        if ($urandom_range(6) == 0)
                            send_request(make_load(pick_load_index()));
                        send_request(make_reloc(j == len));
                    end
                end
            endcase
        end
        drain();
    endtask

    initial
    begin
        tracker = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_TARGET_BASE;
        cfg_data      <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_registers(DIR_BASE, 32'd64, 11'd4);
        send_fields(OP_LOAD, REL_NONE, 32'd0, '0, '0, DIR_BASE + 64'h1000, 1'b0);
        send_fields(OP_LOAD, REL_NONE, 32'd1, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_fields(OP_LOAD, REL_NONE, 32'd2, '0, '0, 64'h7FFF_FFF0, 1'b0);
        send_fields(OP_LOAD, REL_NONE, 32'd3, '0, '0, 64'd0, 1'b0);
        // loads outside the table are dropped
        send_fields(OP_LOAD, REL_NONE, 32'hFFFF_FFFF, '0, '0, rand64(), 1'b0);
        send_fields(OP_LOAD, REL_NONE, SYM_LIMIT, '0, '0, rand64(), 1'b1);
        send_fields(OP_RELOC, REL_NONE, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b0);
        send_fields(OP_RELOC, REL_64, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0);
        send_fields(OP_RELOC, REL_PC32, 32'd0, 64'd8, 64'hFFFF_FFFF_FFFF_FFFC, '0, 1'b0);
        send_fields(OP_RELOC, REL_PLT32, 32'd0, 64'd60, 64'd0, '0, 1'b0);
        send_fields(OP_RELOC, REL_32, 32'd2, 64'd4, 64'h8000_000F, '0, 1'b0);
        // unsigned overflow latches the batch error
        send_fields(OP_RELOC, REL_32, 32'd2, 64'd4, 64'h8000_0010, '0, 1'b0);
        send_fields(OP_RELOC, REL_64, 32'd0, 64'd0, 64'd0, '0, 1'b0);
        send_fields(OP_RELOC, REL_64, 32'd0, 64'd0, 64'd0, '0, 1'b1);
        send_fields(OP_RELOC, REL_32S, 32'd2, 64'd0, 64'hF, '0, 1'b0);
        send_fields(OP_RELOC, REL_32S, 32'd3, 64'd0, 64'hFFFF_FFFF_8000_0000, '0, 1'b1);
        // error on the closing entry leaves no latch behind
        send_fields(OP_RELOC, REL_32S, 32'd3, 64'd0, 64'hFFFF_FFFF_7FFF_FFFF, '0, 1'b1);
        send_fields(OP_RELOC, REL_64, 32'd4, 64'd0, 64'd0, '0, 1'b0);
        send_fields(OP_LOAD, REL_NONE, 32'd4, '0, '0, 64'h55, 1'b0);
        send_fields(OP_RELOC, 32'd3, 32'd0, 64'd0, 64'd0, '0, 1'b1);
        send_fields(OP_RELOC, 32'd3, 32'd0, 64'd0, 64'd0, '0, 1'b1);
        send_fields(OP_RELOC, REL_64, 32'd0, 64'd57, 64'd0, '0, 1'b1);
        send_fields(OP_RELOC, REL_64, 32'd0, 64'd56, 64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b1);
        send_fields(OP_RELOC, REL_PC32, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 1'b1);
        // unsupported type with a bad index reports the index
        send_fields(OP_RELOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0, 64'd0, '0, 1'b1);
        send_fields(OP_RELOC, REL_32, 32'd1, 64'd0, 64'd1, '0, 1'b1);
        drain();

        set_registers(rand64(), 32'd4096, 11'd1024);
        run_phase(150, 0);
        set_registers(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 11'd16);
        run_phase(150, 1);
        set_registers(64'd0, 32'd0, 11'd0);
        run_phase(30, 2);
        set_registers(rand64(), 32'd200, 11'd1);
        run_phase(140, 0);
        set_registers(64'h7FFF_FFFF_FFFF_FF00, $urandom,
                      11'($urandom_range(1, SYMBOL_DEPTH)));
        run_phase(150, 1);
        set_registers(rand64(), 32'd1024, 11'd300);
        run_phase(150, 2);

        $display("relocation engine: %0d requests under %0d register settings, %0d checked",
                 requests_sent, settings_used, tracker.results_checked);
        $display("statuses: ok %0d, none %0d, bad symbol %0d, bad offset %0d, overflow %0d,",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_NONE],
                 tracker.status_seen[ST_BADSYM], tracker.status_seen[ST_BADOFF],
                 tracker.status_seen[ST_OVF]);
        $display("  unsupported %0d, suppressed %0d",
                 tracker.status_seen[ST_UNSUP], tracker.status_seen[ST_SUPP]);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/erpe_pkg.sv
hw/rtl/erpe_ram.sv
hw/rtl/erpe_reloc.sv
hw/rtl/elf_relocation_patch_engine_core.sv
hw/rtl/erpe_checker.sv
tb/reloc_tb_pkg.sv
tb/tb_top.sv
